### rtl/tsq_pkg.sv
// Shared constants, types and register codes of the touch sample qualifier.
package tsq_pkg;

    localparam int SAMPLES_PER_READ = 5;
    localparam int TRIM_COUNT       = 1;
    localparam int SAMPLE_BITS      = 12;

    // The trim is reduced so that at least one sample is always averaged.
    localparam int TRIM_EFF = (2 * TRIM_COUNT >= SAMPLES_PER_READ) ?
                              (SAMPLES_PER_READ - 1) / 2 : TRIM_COUNT;
    localparam int KEEP     = SAMPLES_PER_READ - 2 * TRIM_EFF;
    localparam int KEEP_LOG = $clog2(KEEP);
    localparam int SUM_W    = SAMPLE_BITS + KEEP_LOG;
    localparam int POS_W    = $clog2(SAMPLES_PER_READ);
    localparam int RANK_W   = $clog2(SAMPLES_PER_READ);

    // Reciprocal of KEEP, exact for every sum below 2**SUM_W.
    localparam int     RECIP_SHIFT = SUM_W + KEEP_LOG;
    localparam int     RECIP_W     = SUM_W + 1;
    localparam longint RECIP_L     = ((longint'(1) <<< RECIP_SHIFT) + longint'(KEEP) - 1)
                                     / longint'(KEEP);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    localparam int GRP_W = 2;
    localparam logic [GRP_W-1:0] GRP_X0 = 2'd0;
    localparam logic [GRP_W-1:0] GRP_Y0 = 2'd1;
    localparam logic [GRP_W-1:0] GRP_X1 = 2'd2;
    localparam logic [GRP_W-1:0] GRP_Y1 = 2'd3;

    localparam logic OP_PEN_UP = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic EV_TICK = 1'b0;
    localparam logic EV_MEAN = 1'b1;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_X_GAIN   = 3'd0;
    localparam logic [2:0] REG_Y_GAIN   = 3'd1;
    localparam logic [2:0] REG_X_OFFSET = 3'd2;
    localparam logic [2:0] REG_Y_OFFSET = 3'd3;
    localparam logic [2:0] REG_AGREE    = 3'd4;

    localparam logic signed [15:0] X_GAIN_RST   = -16'sd1460;
    localparam logic signed [15:0] Y_GAIN_RST   = -16'sd1116;
    localparam logic signed [15:0] X_OFFSET_RST = 16'sd340;
    localparam logic signed [15:0] Y_OFFSET_RST = 16'sd260;
    localparam logic [11:0]        AGREE_RST    = 12'd50;

    localparam logic [15:0] NO_TOUCH = 16'hffff;

    typedef struct packed {
        logic                   kind;
        logic [GRP_W-1:0]       grp;
        logic [SAMPLE_BITS-1:0] mean;
    } t_event;

    typedef struct packed {
        logic signed [15:0] x_gain;
        logic signed [15:0] y_gain;
        logic signed [15:0] x_offset;
        logic signed [15:0] y_offset;
        logic [11:0]        agree_range;
    } t_cfg;

endpackage

### rtl/tsq_if.sv
// Valid/ready channel interfaces for input items and result items.
interface tsq_in_if import tsq_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   opcode;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, opcode, sample, input ready);
    modport sink (input valid, opcode, sample, output ready);
endinterface

interface tsq_out_if import tsq_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [15:0] x_position;
    logic [15:0] y_position;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic        pen_down;
    logic        reading_valid;

    modport source (output valid, x_position, y_position, start_x, start_y, pen_down,
                    reading_valid, input ready);
    modport sink (input valid, x_position, y_position, start_x, start_y, pen_down,
                  reading_valid, output ready);
endinterface

### rtl/touch_sample_qualifier_top.sv
// Top level of the touch sample qualifier: register port and the three parts.
//
// The block takes one item per clock cycle without pause as long as results are taken.
// A pen-up tick, or the sample that ends a scan, yields its result once it has passed
// three front stages (group store, trim and sum, reciprocal multiply), one queue slot
// and the output register. Other samples yield no result. The four-entry queue lets
// the front keep taking samples while a result waits at the output; input ready drops
// only once the queue is full behind a stalled output. Registers sit at byte addresses
// 0, 4, 8, 12 and 16 (x_gain, y_gain, x_offset, y_offset, agree_range); the user must
// write them only while no item is in flight, and the block does not enforce this.
module touch_sample_qualifier_top import tsq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tsq_in_if.sink            i_in,
    tsq_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg       r_cfg;
    logic       cfg_wr;
    logic [2:0] reg_idx;

    logic       ev_valid, ev_ready, q_valid, q_ready;
    t_event     ev, q_ev;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_gain      <= X_GAIN_RST;
            r_cfg.y_gain      <= Y_GAIN_RST;
            r_cfg.x_offset    <= X_OFFSET_RST;
            r_cfg.y_offset    <= Y_OFFSET_RST;
            r_cfg.agree_range <= AGREE_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_X_GAIN:   r_cfg.x_gain      <= pwdata[15:0];
                REG_Y_GAIN:   r_cfg.y_gain      <= pwdata[15:0];
                REG_X_OFFSET: r_cfg.x_offset    <= pwdata[15:0];
                REG_Y_OFFSET: r_cfg.y_offset    <= pwdata[15:0];
                REG_AGREE:    r_cfg.agree_range <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_X_GAIN:   prdata = {16'd0, r_cfg.x_gain};
            REG_Y_GAIN:   prdata = {16'd0, r_cfg.y_gain};
            REG_X_OFFSET: prdata = {16'd0, r_cfg.x_offset};
            REG_Y_OFFSET: prdata = {16'd0, r_cfg.y_offset};
            REG_AGREE:    prdata = {20'd0, r_cfg.agree_range};
            default:      prdata = 32'd0;
        endcase
    end

    tsq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_ev_valid (ev_valid),
        .o_ev       (ev),
        .i_ev_ready (ev_ready)
    );

    tsq_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (ev_valid),
        .o_push_ready (ev_ready),
        .i_push_ev    (ev),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_ev     (q_ev)
    );

    tsq_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_ev_valid (q_valid),
        .o_ev_ready (q_ready),
        .i_ev       (q_ev),
        .o_out      (o_out)
    );

endmodule

### rtl/tsq_front.sv
// Front end: takes items, fills the sample group and computes trimmed means.
module tsq_front import tsq_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tsq_in_if.sink i_in,
    output logic   o_ev_valid,
    output t_event o_ev,
    input  logic   i_ev_ready
);

    localparam int PROD_W = SUM_W + RECIP_W;

    logic [SAMPLE_BITS-1:0] r_store [SAMPLES_PER_READ];
    logic [POS_W-1:0]       r_pos;
    logic [GRP_W-1:0]       r_grp;

    logic                   r_s1_v, r_s1_kind;
    logic [GRP_W-1:0]       r_s1_grp;
    logic                   r_s2_v, r_s2_kind;
    logic [GRP_W-1:0]       r_s2_grp;
    logic [SUM_W-1:0]       r_s2_sum;
    logic                   r_s3_v, r_s3_kind;
    logic [GRP_W-1:0]       r_s3_grp;
    logic [SAMPLE_BITS-1:0] r_s3_mean;

    logic                   adv, accept, last, is_tick;
    logic [RANK_W-1:0]      rank [SAMPLES_PER_READ];
    logic [SUM_W-1:0]       kept_sum;
    logic [PROD_W-1:0]      prod;

    assign adv        = !r_s3_v || i_ev_ready;
    assign i_in.ready = adv;
    assign accept     = i_in.valid && adv;
    assign is_tick    = i_in.opcode == OP_PEN_UP;
    assign last       = r_pos == POS_W'(SAMPLES_PER_READ - 1);

    // Stable rank of each stored sample; the middle ranks are the kept ones.
    always_comb begin
        kept_sum = '0;
        for (int i = 0; i < SAMPLES_PER_READ; i++) begin
            rank[i] = '0;
            for (int j = 0; j < SAMPLES_PER_READ; j++) begin
                if (j != i && ((r_store[j] < r_store[i]) ||
                               (r_store[j] == r_store[i] && j < i))) begin
                    rank[i] = rank[i] + RANK_W'(1);
                end
            end
            if (int'(rank[i]) >= TRIM_EFF && int'(rank[i]) < SAMPLES_PER_READ - TRIM_EFF) begin
                kept_sum = kept_sum + SUM_W'(r_store[i]);
            end
        end
    end

    assign prod = PROD_W'(r_s2_sum) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (accept && !is_tick) begin
            r_store[r_pos] <= i_in.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_grp  <= GRP_X0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (accept) begin
                if (is_tick) begin
                    r_pos <= '0;
                    r_grp <= GRP_X0;
                end else if (last) begin
                    r_pos <= '0;
                    r_grp <= r_grp + GRP_W'(1);
                end else begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
            if (adv) begin
                r_s1_v <= accept && (is_tick || last);
                r_s2_v <= r_s1_v;
                r_s3_v <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_kind <= is_tick ? EV_TICK : EV_MEAN;
            r_s1_grp  <= r_grp;
            r_s2_kind <= r_s1_kind;
            r_s2_grp  <= r_s1_grp;
            r_s2_sum  <= kept_sum;
            r_s3_kind <= r_s2_kind;
            r_s3_grp  <= r_s2_grp;
            r_s3_mean <= prod[RECIP_SHIFT +: SAMPLE_BITS];
        end
    end

    assign o_ev_valid = r_s3_v;
    assign o_ev.kind  = r_s3_kind;
    assign o_ev.grp   = r_s3_grp;
    assign o_ev.mean  = r_s3_mean;

endmodule

### rtl/tsq_queue.sv
// Short queue of classified items between the front end and the back end.
module tsq_queue import tsq_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    output logic   o_push_ready,
    input  t_event i_push_ev,
    output logic   o_pop_valid,
    input  logic   i_pop_ready,
    output t_event o_pop_ev
);

    t_event             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_PTR_W:0]   r_cnt;
    logic               push, pop;

    assign o_push_ready = r_cnt != (Q_PTR_W + 1)'(Q_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_ev     = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + (Q_PTR_W + 1)'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - (Q_PTR_W + 1)'(1);
            end
        end
    end

endmodule

### rtl/tsq_back.sv
// Back end: keeps the readings and the touch state, qualifies, calibrates and emits.
module tsq_back import tsq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_ev_valid,
    output logic       o_ev_ready,
    input  t_event     i_ev,
    tsq_out_if.source  o_out
);

    localparam int CAL_W = ((SAMPLE_BITS + 17) > 30 ? SAMPLE_BITS + 17 : 30) + 1;

    logic [SAMPLE_BITS-1:0] r_first_x, r_first_y, r_second_x;
    logic [SAMPLE_BITS-1:0] n_first_x, n_first_y, n_second_x;
    logic [15:0]            r_cur_x, r_cur_y, r_start_x, r_start_y;
    logic [15:0]            n_cur_x, n_cur_y, n_start_x, n_start_y;
    logic                   r_held, n_held;

    logic                   r_out_v, r_out_pen, r_out_rv;
    logic [15:0]            r_out_x, r_out_y, r_out_sx, r_out_sy;

    logic                   out_free, take, emits, is_tick, is_scan_end;
    logic                   agree_x, agree_y, scan_ok;
    logic [SAMPLE_BITS:0]   sum_x, sum_y;
    logic [15:0]            cal_x, cal_y;

    function automatic logic [SAMPLE_BITS-1:0] abs_diff(input logic [SAMPLE_BITS-1:0] a,
                                                        input logic [SAMPLE_BITS-1:0] b);
        abs_diff = (a > b) ? a - b : b - a;
    endfunction

    // gain * raw / 2**14 + offset, computed as one sum and clamped to 16 bits.
    function automatic logic [15:0] calibrate(input logic [SAMPLE_BITS-1:0] raw,
                                              input logic signed [15:0] gain,
                                              input logic signed [15:0] offset);
        logic signed [CAL_W-1:0] acc;
        logic signed [CAL_W-1:0] q;
        acc = CAL_W'(gain) * $signed(CAL_W'(raw)) + (CAL_W'(offset) <<< 14);
        q   = acc >>> 14;
        if (acc < 0) begin
            calibrate = 16'd0;
        end else if (|q[CAL_W-1:16]) begin
            calibrate = 16'hffff;
        end else begin
            calibrate = q[15:0];
        end
    endfunction

    assign is_tick     = i_ev.kind == EV_TICK;
    assign is_scan_end = i_ev.kind == EV_MEAN && i_ev.grp == GRP_Y1;
    assign out_free    = !r_out_v || o_out.ready;
    assign o_ev_ready  = !(is_tick || is_scan_end) || out_free;
    assign take        = i_ev_valid && o_ev_ready;
    assign emits       = take && (is_tick || is_scan_end);

    assign agree_x = int'(abs_diff(r_first_x, r_second_x)) < int'(i_cfg.agree_range);
    assign agree_y = int'(abs_diff(r_first_y, i_ev.mean)) < int'(i_cfg.agree_range);
    assign scan_ok = agree_x && agree_y;

    assign sum_x = {1'b0, r_first_x} + {1'b0, r_second_x};
    assign sum_y = {1'b0, r_first_y} + {1'b0, i_ev.mean};
    assign cal_x = calibrate(sum_x[SAMPLE_BITS:1], i_cfg.x_gain, i_cfg.x_offset);
    assign cal_y = calibrate(sum_y[SAMPLE_BITS:1], i_cfg.y_gain, i_cfg.y_offset);

    always_comb begin
        n_first_x  = r_first_x;
        n_first_y  = r_first_y;
        n_second_x = r_second_x;
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_start_x  = r_start_x;
        n_start_y  = r_start_y;
        n_held     = r_held;
        if (take) begin
            case (i_ev.kind)
                EV_TICK: begin
                    // A tick while held only ends the touch; otherwise it clears the position.
                    if (r_held) begin
                        n_held = 1'b0;
                    end else begin
                        n_start_x = 16'd0;
                        n_start_y = 16'd0;
                        n_cur_x   = NO_TOUCH;
                        n_cur_y   = NO_TOUCH;
                    end
                end
                EV_MEAN: begin
                    case (i_ev.grp)
                        GRP_X0: n_first_x  = i_ev.mean;
                        GRP_Y0: n_first_y  = i_ev.mean;
                        GRP_X1: n_second_x = i_ev.mean;
                        GRP_Y1: begin
                            if (scan_ok) begin
                                n_cur_x = cal_x;
                                n_cur_y = cal_y;
                            end
                            if (!r_held) begin
                                n_held    = 1'b1;
                                n_start_x = n_cur_x;
                                n_start_y = n_cur_y;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_x  <= '0;
            r_first_y  <= '0;
            r_second_x <= '0;
            r_cur_x    <= '0;
            r_cur_y    <= '0;
            r_start_x  <= '0;
            r_start_y  <= '0;
            r_held     <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_first_x  <= n_first_x;
            r_first_y  <= n_first_y;
            r_second_x <= n_second_x;
            r_cur_x    <= n_cur_x;
            r_cur_y    <= n_cur_y;
            r_start_x  <= n_start_x;
            r_start_y  <= n_start_y;
            r_held     <= n_held;
            if (emits) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emits) begin
            r_out_x   <= n_cur_x;
            r_out_y   <= n_cur_y;
            r_out_sx  <= n_start_x;
            r_out_sy  <= n_start_y;
            r_out_pen <= n_held;
            r_out_rv  <= is_scan_end && scan_ok;
        end
    end

    assign o_out.valid         = r_out_v;
    assign o_out.x_position    = r_out_x;
    assign o_out.y_position    = r_out_y;
    assign o_out.start_x       = r_out_sx;
    assign o_out.start_y       = r_out_sy;
    assign o_out.pen_down      = r_out_pen;
    assign o_out.reading_valid = r_out_rv;

endmodule

### rtl/tsq_checker.sv
// Port-level checks of the touch sample qualifier and their binding to the top level.
module tsq_checker import tsq_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_pen_down,
    input logic              i_reading_valid,
    input logic              i_psel,
    input logic              i_penable,
    input logic              i_pwrite,
    input logic [ADDR_W-1:0] i_paddr,
    input logic [31:0]       i_pwdata,
    input logic [31:0]       i_prdata
);

    // A result waiting at the output stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before it was taken");

    // An agreeing scan always leaves the pen down.
    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (!i_reading_valid || i_pen_down))
        else $error("reading_valid without pen_down");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    // A written x_gain reads back at address 0 right after the write.
    a_gain_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_psel && i_penable && i_pwrite && i_paddr == ADDR_W'(0)) ##1 (i_paddr == ADDR_W'(0))
        |-> i_prdata[15:0] == $past(i_pwdata[15:0]))
        else $error("x_gain readback differs from the written value");

endmodule

bind touch_sample_qualifier_top tsq_checker u_tsq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_pen_down      (o_out.pen_down),
    .i_reading_valid (o_out.reading_valid),
    .i_psel          (psel),
    .i_penable       (penable),
    .i_pwrite        (pwrite),
    .i_paddr         (paddr),
    .i_pwdata        (pwdata),
    .i_prdata        (prdata)
);
